>>> rtl/core/oab_pkg.sv
// shared types, constants and helper functions for the straight alpha over blend pipeline
// no dependencies; used by every module in rtl/core
`default_nettype none

package oab_pkg;

    localparam int unsigned NumLanes   = 3;
    localparam logic [7:0]  Full       = 8'hFF;
    // reciprocal of 255 scaled by 2**23, rounded down so the estimate never overshoots
    localparam logic [15:0] Recip255   = 16'd32896;
    localparam int unsigned RecipShift = 23;
    localparam int unsigned DivStages  = 4;

    typedef logic [7:0] t_chan;

    // after the product stages
    typedef struct packed {
        logic                  bypass;
        logic [31:0]           dst;
        t_chan                 inv;
        t_chan                 oa;
        logic [2:0][15:0]      sa;
        logic [2:0][15:0]      dda;
    } t_prod;

    // after the mix stages: numerators ready for the divider
    typedef struct packed {
        logic                  bypass;
        logic [31:0]           dst;
        t_chan                 oa;
        logic [2:0][16:0]      num;
    } t_num;

    // after the divider: quotients with overflow flags
    typedef struct packed {
        logic                  bypass;
        logic [31:0]           dst;
        t_chan                 oa;
        logic [2:0]            ovf;
        logic [2:0][7:0]       quo;
    } t_quot;

    // floor(x / 255) for x up to 255 * 255
    function automatic t_chan div255_16(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // colour channel of a packed pixel: lane 0 red, 1 green, 2 blue
    function automatic t_chan color_lane(input logic [31:0] px, input int unsigned lane);
        return px[31 - 8 * lane -: 8];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/oab_alpha.sv
// two pipeline stages: coverage-scaled alpha, blended alpha and the per-channel products
// depends on oab_pkg
`default_nettype none

module oab_alpha (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [31:0]   i_src_color,
    input  wire logic [7:0]    i_coverage,
    input  wire logic [31:0]   i_dst_pixel,
    output logic               o_valid,
    input  wire logic          i_ready,
    output oab_pkg::t_prod     o_item
);

    logic                r1_vld;
    oab_pkg::t_chan      r1_a;
    logic [31:0]         r1_src;
    logic [31:0]         r1_dst;
    logic                r2_vld;
    oab_pkg::t_prod      r2_item;

    oab_pkg::t_chan      n1_a;
    oab_pkg::t_prod      n2_item;
    logic                en1;
    logic                en2;

    // stage enables, a bubble collapses under a stall
    assign en2     = !r2_vld || i_ready;
    assign en1     = !r1_vld || en2;
    assign o_ready = en1;
    assign o_valid = r2_vld;
    assign o_item  = r2_item;

    // scaled source alpha
    assign n1_a = oab_pkg::div255_16({8'd0, i_src_color[7:0]} * {8'd0, i_coverage});

    // blended alpha and channel products
    always_comb begin : prod_comb
        oab_pkg::t_chan da;
        oab_pkg::t_chan inv;
        da  = r1_dst[7:0];
        inv = oab_pkg::Full - r1_a;
        n2_item.bypass = (r1_a == 8'd0);
        n2_item.dst    = r1_dst;
        n2_item.inv    = inv;
        n2_item.oa     = r1_a + oab_pkg::div255_16({8'd0, da} * {8'd0, inv});
        for (int unsigned l = 0; l < oab_pkg::NumLanes; l++) begin
            n2_item.sa[l]  = {8'd0, oab_pkg::color_lane(r1_src, l)} * {8'd0, r1_a};
            n2_item.dda[l] = {8'd0, oab_pkg::color_lane(r1_dst, l)} * {8'd0, da};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (en1) r1_vld <= i_valid;
            if (en2) r2_vld <= r1_vld;
        end
        if (en1) begin
            r1_a   <= n1_a;
            r1_src <= i_src_color;
            r1_dst <= i_dst_pixel;
        end
        if (en2) r2_item <= n2_item;
    end

endmodule

`default_nettype wire

>>> rtl/core/oab_mix.sv
// three pipeline stages: destination term d*dA*inv/255 by reciprocal multiply, then numerators
// depends on oab_pkg
`default_nettype none

module oab_mix (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire oab_pkg::t_prod i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output oab_pkg::t_num      o_item
);

    localparam int unsigned ProdW = 40;

    logic                r3_vld;
    logic                r3_bypass;
    logic [31:0]         r3_dst;
    oab_pkg::t_chan      r3_oa;
    logic [2:0][15:0]    r3_sa;
    logic [2:0][23:0]    r3_y;
    logic                r4_vld;
    logic                r4_bypass;
    logic [31:0]         r4_dst;
    oab_pkg::t_chan      r4_oa;
    logic [2:0][15:0]    r4_sa;
    logic [2:0][23:0]    r4_y;
    logic [2:0][15:0]    r4_qe;
    logic                r5_vld;
    oab_pkg::t_num       r5_item;

    logic [2:0][23:0]    n3_y;
    logic [2:0][15:0]    n4_qe;
    oab_pkg::t_num       n5_item;
    logic                en3;
    logic                en4;
    logic                en5;

    assign en5     = !r5_vld || i_ready;
    assign en4     = !r4_vld || en5;
    assign en3     = !r3_vld || en4;
    assign o_ready = en3;
    assign o_valid = r5_vld;
    assign o_item  = r5_item;

    // d*dA times inverse alpha
    always_comb begin
        for (int unsigned l = 0; l < oab_pkg::NumLanes; l++) begin
            n3_y[l] = {8'd0, i_item.dda[l]} * {16'd0, i_item.inv};
        end
    end

    // quotient estimate, equal to the floor or one below it
    always_comb begin : est_comb
        logic [ProdW-1:0] p;
        p = '0;
        for (int unsigned l = 0; l < oab_pkg::NumLanes; l++) begin
            p = {16'd0, r3_y[l]} * {24'd0, oab_pkg::Recip255};
            n4_qe[l] = p[oab_pkg::RecipShift +: 16];
        end
    end

    // one correction step, then add the source term
    always_comb begin : fix_comb
        logic [23:0] rem;
        logic [15:0] q;
        rem = '0;
        q   = '0;
        n5_item.bypass = r4_bypass;
        n5_item.dst    = r4_dst;
        n5_item.oa     = r4_oa;
        for (int unsigned l = 0; l < oab_pkg::NumLanes; l++) begin
            rem = r4_y[l] - ({r4_qe[l], 8'd0} - {8'd0, r4_qe[l]});
            q   = (rem >= {16'd0, oab_pkg::Full}) ? r4_qe[l] + 16'd1 : r4_qe[l];
            n5_item.num[l] = {1'b0, r4_sa[l]} + {1'b0, q};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            if (en3) r3_vld <= i_valid;
            if (en4) r4_vld <= r3_vld;
            if (en5) r5_vld <= r4_vld;
        end
        if (en3) begin
            r3_bypass <= i_item.bypass;
            r3_dst    <= i_item.dst;
            r3_oa     <= i_item.oa;
            r3_sa     <= i_item.sa;
            r3_y      <= n3_y;
        end
        if (en4) begin
            r4_bypass <= r3_bypass;
            r4_dst    <= r3_dst;
            r4_oa     <= r3_oa;
            r4_sa     <= r3_sa;
            r4_y      <= r3_y;
            r4_qe     <= n4_qe;
        end
        if (en5) r5_item <= n5_item;
    end

endmodule

`default_nettype wire

>>> rtl/core/oab_div.sv
// pipelined restoring divider, three lanes, two quotient bits per stage
// depends on oab_pkg; flags quotients above 255 instead of computing them
`default_nettype none

module oab_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire oab_pkg::t_num i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output oab_pkg::t_quot     o_item
);

    localparam int unsigned NSt = oab_pkg::DivStages;

    logic [NSt-1:0]      r_vld;
    logic                r_bypass [NSt];
    logic [31:0]         r_dst    [NSt];
    oab_pkg::t_chan      r_oa     [NSt];
    logic [2:0]          r_ovf    [NSt];
    logic [2:0][16:0]    r_rem    [NSt];
    logic [2:0][7:0]     r_quo    [NSt];

    logic [2:0]          n_ovf;
    logic [2:0][16:0]    n_rem    [NSt];
    logic [2:0][7:0]     n_quo    [NSt];
    logic [NSt-1:0]      en;
    logic [2:0][16:0]    s_rem    [NSt];
    logic [2:0][7:0]     s_quo    [NSt];
    oab_pkg::t_chan      s_dv     [NSt];

    // stage enables from the output side back
    always_comb begin
        en[NSt-1] = !r_vld[NSt-1] || i_ready;
        for (int k = NSt - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSt-1];

    always_comb begin
        o_item.bypass = r_bypass[NSt-1];
        o_item.dst    = r_dst[NSt-1];
        o_item.oa     = r_oa[NSt-1];
        o_item.ovf    = r_ovf[NSt-1];
        o_item.quo    = r_quo[NSt-1];
    end

    // quotient above 255 exactly when num >= 256 * oa
    always_comb begin
        for (int unsigned l = 0; l < oab_pkg::NumLanes; l++) begin
            n_ovf[l] = (i_item.num[l][16:8] >= {1'b0, i_item.oa});
        end
    end

    // stage operands: the incoming request for the first stage, the stage before otherwise
    always_comb begin
        s_rem[0] = i_item.num;
        s_quo[0] = '0;
        s_dv[0]  = i_item.oa;
        for (int k = 1; k < NSt; k++) begin
            s_rem[k] = r_rem[k-1];
            s_quo[k] = r_quo[k-1];
            s_dv[k]  = r_oa[k-1];
        end
    end

    // two shift-subtract steps per stage
    always_comb begin : step_comb
        logic [16:0]    rem;
        logic [7:0]     q;
        logic [16:0]    dsh;
        oab_pkg::t_chan dv;
        int             b;
        rem = '0;
        q   = '0;
        dsh = '0;
        dv  = '0;
        b   = 0;
        for (int k = 0; k < NSt; k++) begin
            dv = s_dv[k];
            for (int unsigned l = 0; l < oab_pkg::NumLanes; l++) begin
                rem = s_rem[k][l];
                q   = s_quo[k][l];
                for (int j = 0; j < 2; j++) begin
                    b   = 7 - 2 * k - j;
                    dsh = {9'd0, dv} << b;
                    if (rem >= dsh) begin
                        rem  = rem - dsh;
                        q[b] = 1'b1;
                    end
                end
                n_rem[k][l] = rem;
                n_quo[k][l] = q;
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSt; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
        if (en[0]) begin
            r_bypass[0] <= i_item.bypass;
            r_dst[0]    <= i_item.dst;
            r_oa[0]     <= i_item.oa;
            r_ovf[0]    <= n_ovf;
        end
        for (int k = 1; k < NSt; k++) begin
            if (en[k]) begin
                r_bypass[k] <= r_bypass[k-1];
                r_dst[k]    <= r_dst[k-1];
                r_oa[k]     <= r_oa[k-1];
                r_ovf[k]    <= r_ovf[k-1];
            end
        end
        for (int k = 0; k < NSt; k++) begin
            if (en[k]) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/straight_alpha_over_blend.sv
// top level of the straight alpha over blend pipeline: chains the stages and holds
// the output register and the alpha lock register; depends on oab_pkg and all oab_ modules
`default_nettype none

//  channel   signals                                   direction
//  request   i_valid/o_ready, src_color coverage dst   in
//  result    o_valid/i_ready, out_pixel written        out
//  config    i_alpha_lock_we, i_alpha_lock             in, write only
//
//  one pixel per cycle sustained while i_ready stays high; 10 register stages, in order
//  2 alpha/product stages, 3 mix stages, 4 divider stages and 1 output stage
//  every stage holds its own valid bit, so a stall loses nothing and bubbles collapse
//  synchronous active low reset clears valid bits and alpha lock

module straight_alpha_over_blend (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_alpha_lock_we,
    input  wire logic          i_alpha_lock,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [31:0]   i_src_color,
    input  wire logic [7:0]    i_coverage,
    input  wire logic [31:0]   i_dst_pixel,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_out_pixel,
    output logic               o_written
);

    oab_pkg::t_prod   prod_item;
    oab_pkg::t_num    num_item;
    oab_pkg::t_quot   quo_item;
    logic             prod_vld;
    logic             prod_rdy;
    logic             num_vld;
    logic             num_rdy;
    logic             quo_vld;
    logic             quo_rdy;

    logic             r_alpha_lock;
    logic             r_out_vld;
    logic [31:0]      r_out_pixel;
    logic             r_written;
    logic [31:0]      n_out_pixel;

    oab_alpha u_alpha (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_src_color (i_src_color),
        .i_coverage  (i_coverage),
        .i_dst_pixel (i_dst_pixel),
        .o_valid     (prod_vld),
        .i_ready     (prod_rdy),
        .o_item      (prod_item)
    );

    oab_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_vld),
        .o_ready (prod_rdy),
        .i_item  (prod_item),
        .o_valid (num_vld),
        .i_ready (num_rdy),
        .o_item  (num_item)
    );

    oab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (num_vld),
        .o_ready (num_rdy),
        .i_item  (num_item),
        .o_valid (quo_vld),
        .i_ready (quo_rdy),
        .o_item  (quo_item)
    );

    assign quo_rdy     = !r_out_vld || i_ready;
    assign o_valid     = r_out_vld;
    assign o_out_pixel = r_out_pixel;
    assign o_written   = r_written;

    // saturate channels, pick alpha, pass destination through when nothing is drawn
    always_comb begin
        n_out_pixel[7:0] = r_alpha_lock ? quo_item.dst[7:0] : quo_item.oa;
        for (int unsigned l = 0; l < oab_pkg::NumLanes; l++) begin
            n_out_pixel[31 - 8 * l -: 8] = quo_item.ovf[l] ? oab_pkg::Full : quo_item.quo[l];
        end
        if (quo_item.bypass) begin
            n_out_pixel = quo_item.dst;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lock <= 1'b0;
        end else if (i_alpha_lock_we) begin
            r_alpha_lock <= i_alpha_lock;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (quo_rdy) begin
            r_out_vld <= quo_vld;
        end
        if (quo_rdy) begin
            r_out_pixel <= n_out_pixel;
            r_written   <= !quo_item.bypass;
        end
    end

endmodule

`default_nettype wire
